>>> hw/rtl/miex_pkg.sv
// ----------------------------------------------------------------------------
// miex_pkg: shared types and constants
// Opcodes, beat payload structs and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package miex_pkg;

   localparam int MemBytes  = 1024;
   localparam int MemAw     = $clog2(MemBytes);
   localparam int MemWords  = MemBytes / 4;
   localparam int WordAw    = MemAw - 2;
   localparam int NumRegs   = 32;

   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05;
   localparam logic [5:0] OP_ADDI  = 6'h08;
   localparam logic [5:0] OP_ADDIU = 6'h09;
   localparam logic [5:0] OP_SLTI  = 6'h0A;
   localparam logic [5:0] OP_ANDI  = 6'h0C;
   localparam logic [5:0] OP_ORI   = 6'h0D;
   localparam logic [5:0] OP_NORI  = 6'h0E;
   localparam logic [5:0] OP_LUI   = 6'h0F;
   localparam logic [5:0] OP_LB    = 6'h20;
   localparam logic [5:0] OP_LH    = 6'h21;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_LBU   = 6'h24;
   localparam logic [5:0] OP_LHU   = 6'h25;
   localparam logic [5:0] OP_SB    = 6'h28;
   localparam logic [5:0] OP_SH    = 6'h29;
   localparam logic [5:0] OP_SW    = 6'h2B;

   typedef enum logic [2:0] {
      CLS_NONE, CLS_ALU, CLS_BRANCH, CLS_LOAD, CLS_STORE
   } class_type;

   typedef struct packed {
      logic [5:0]         func;
      logic [4:0]         src_reg;
      logic [4:0]         tgt_reg;
      logic signed [15:0] immediate;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        zero_write_flag;
      logic        overflow_flag;
      logic        address_error;
      logic        misaligned_error;
   } rsp_type;

   typedef struct packed {
      req_type    req;
      class_type  cls;
      logic [2:0] size;
      logic       ld_signed;
   } entry_type;

endpackage

>>> hw/rtl/miex_front.sv
// ----------------------------------------------------------------------------
// miex_front: instruction classifier
// Decodes the opcode and pushes classified beats into a two-entry queue.
// ----------------------------------------------------------------------------
module miex_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  miex_pkg::req_type   req_data,
   output logic                q_valid,
   input  logic                q_ready,
   output miex_pkg::entry_type q_data
);
   import miex_pkg::*;

   entry_type  ent_in;
   entry_type  slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   always_comb begin
      ent_in           = '0;
      ent_in.req       = req_data;
      ent_in.cls       = CLS_NONE;
      case (req_data.func)
         OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_NORI, OP_LUI:
            ent_in.cls = CLS_ALU;
         OP_BEQ, OP_BNE: ent_in.cls = CLS_BRANCH;
         OP_LB:  begin ent_in.cls = CLS_LOAD; ent_in.size = 3'd1; ent_in.ld_signed = 1'b1; end
         OP_LBU: begin ent_in.cls = CLS_LOAD; ent_in.size = 3'd1; end
         OP_LH:  begin ent_in.cls = CLS_LOAD; ent_in.size = 3'd2; ent_in.ld_signed = 1'b1; end
         OP_LHU: begin ent_in.cls = CLS_LOAD; ent_in.size = 3'd2; end
         OP_LW:  begin ent_in.cls = CLS_LOAD; ent_in.size = 3'd4; end
         OP_SB:  begin ent_in.cls = CLS_STORE; ent_in.size = 3'd1; end
         OP_SH:  begin ent_in.cls = CLS_STORE; ent_in.size = 3'd2; end
         OP_SW:  begin ent_in.cls = CLS_STORE; ent_in.size = 3'd4; end
         default: ent_in.cls = CLS_NONE;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;
   assign rd_ptr_in = rd_ptr_ff ^ pop;
   assign wr_ptr_in = wr_ptr_ff ^ push;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= ent_in;
      end
   end

endmodule

>>> hw/rtl/miex_back.sv
// ----------------------------------------------------------------------------
// miex_back: execution engine
// Two-phase execute: read operands and memory word, then write back and
// publish the result beat.
// ----------------------------------------------------------------------------
module miex_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  miex_pkg::entry_type q_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output miex_pkg::rsp_type   rsp_data
);
   import miex_pkg::*;

   // Register file with per-entry valid bits; memory cleared by a sweep.
   logic [31:0]         rf_ff [NumRegs];
   logic [NumRegs-1:0]  rfv_ff;
   logic [31:0]         mem [MemWords];
   logic [31:0]         pc_ff;

   logic                busy_ff, busy_in;
   logic                clr_ff;
   logic [WordAw:0]     clr_cnt_ff;
   entry_type           ent_ff;
   logic [31:0]         rsv_ff, rtv_ff, mword_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic [31:0]         rsv, rtv, simm, zimm, wval, mw_new, pc4;
   logic signed [32:0]  sum;
   logic                ovf, aerr, merr, zw, do_rf, do_mem, ok;
   logic [31:0]         npc;
   logic [MemAw-1:0]    addr;
   logic [1:0]          boff;
   logic [31:0]         ldv;
   logic [7:0]          lb;
   logic [15:0]         lh;
   logic                accept;

   assign q_ready   = !busy_ff && !clr_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = q_valid && q_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      rsv = rfv_ff[q_data.req.src_reg] ? rf_ff[q_data.req.src_reg] : 32'd0;
      rtv = rfv_ff[q_data.req.tgt_reg] ? rf_ff[q_data.req.tgt_reg] : 32'd0;
   end

   // Phase one: latch operands and fetch the addressed memory word.
   logic signed [32:0] asum;
   assign asum = $signed({q_data.req.src_reg == 5'd0 ? 1'b0 : rsv[31], rsv})
               + 33'(q_data.req.immediate);

   always_ff @(posedge clock) begin
      if (accept) begin
         ent_ff   <= q_data;
         rsv_ff   <= rsv;
         rtv_ff   <= rtv;
         mword_ff <= mem[asum[MemAw-1:2]];
      end
   end

   // Phase two: compute everything from registered operands.
   always_comb begin
      simm = {{16{ent_ff.req.immediate[15]}}, ent_ff.req.immediate};
      zimm = {16'd0, ent_ff.req.immediate};
      sum  = $signed({rsv_ff[31], rsv_ff}) + $signed({simm[31], simm});
      ovf  = 1'b0; aerr = 1'b0; merr = 1'b0; zw = 1'b0;
      do_rf = 1'b0; do_mem = 1'b0; wval = '0;
      pc4  = pc_ff + 32'd4;
      npc  = pc_ff;
      addr = sum[MemAw-1:0];
      boff = sum[1:0];
      lb   = mword_ff[8*(3-boff) +: 8];
      lh   = boff[1] ? mword_ff[15:0] : mword_ff[31:16];
      ldv  = '0;
      mw_new = mword_ff;
      ok   = 1'b0;
      case (ent_ff.cls)
         CLS_ALU: begin
            zw = (ent_ff.req.tgt_reg == 5'd0);
            do_rf = 1'b1;
            npc = pc4;
            case (ent_ff.req.func)
               OP_ADDI: begin wval = sum[31:0]; ovf = sum[32] != sum[31]; end
               OP_ADDIU: wval = sum[31:0];
               OP_SLTI:  wval = {31'd0, $signed(rsv_ff) < $signed(simm)};
               OP_ANDI:  wval = rsv_ff & zimm;
               OP_ORI:   wval = rsv_ff | zimm;
               OP_NORI:  wval = ~(rsv_ff | zimm);
               OP_LUI:   wval = {ent_ff.req.immediate, 16'd0};
               default:  wval = '0;
            endcase
         end
         CLS_BRANCH: begin
            if ((ent_ff.req.func == OP_BEQ) == (rsv_ff == rtv_ff)) begin
               npc = pc4 + {simm[29:0], 2'b00};
            end else begin
               npc = pc4;
            end
         end
         CLS_LOAD, CLS_STORE: begin
            zw  = (ent_ff.cls == CLS_LOAD) && (ent_ff.req.tgt_reg == 5'd0);
            ovf = sum[32] != sum[31];
            // Blocks are word aligned and memory is a multiple of four bytes,
            // so an aligned access never runs past the end.
            if (sum[32] || (sum[31:0] >= 32'(MemBytes))) begin
               aerr = 1'b1;
            end else if ((ent_ff.size == 3'd2 && sum[0]) ||
                         (ent_ff.size == 3'd4 && sum[1:0] != 2'b00)) begin
               merr = 1'b1;
            end else begin
               ok  = 1'b1;
               npc = pc4;
            end
            case (ent_ff.size)
               3'd1: ldv = ent_ff.ld_signed ? {{24{lb[7]}}, lb} : {24'd0, lb};
               3'd2: ldv = ent_ff.ld_signed ? {{16{lh[15]}}, lh} : {16'd0, lh};
               default: ldv = mword_ff;
            endcase
            case (ent_ff.size)
               3'd1: mw_new[8*(3-boff) +: 8] = rtv_ff[7:0];
               3'd2: begin
                  if (boff[1]) begin
                     mw_new[15:0] = rtv_ff[15:0];
                  end else begin
                     mw_new[31:16] = rtv_ff[15:0];
                  end
               end
               default: mw_new = rtv_ff;
            endcase
            wval   = ldv;
            do_rf  = ok && (ent_ff.cls == CLS_LOAD);
            do_mem = ok && (ent_ff.cls == CLS_STORE);
         end
         default: npc = pc_ff;
      endcase
      busy_in = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rfv_ff       <= '0;
         pc_ff        <= '0;
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == (WordAw+1)'(MemWords - 1)) begin
               clr_ff <= 1'b0;
            end
         end
         if (busy_ff) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= npc;
            if (do_rf && ent_ff.req.tgt_reg != 5'd0) begin
               rfv_ff[ent_ff.req.tgt_reg] <= 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rsp_ff.next_pc          <= npc;
         rsp_ff.zero_write_flag  <= zw;
         rsp_ff.overflow_flag    <= ovf;
         rsp_ff.address_error    <= aerr;
         rsp_ff.misaligned_error <= merr;
         if (do_rf && ent_ff.req.tgt_reg != 5'd0) begin
            rf_ff[ent_ff.req.tgt_reg] <= wval;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_cnt_ff[WordAw-1:0]] <= '0;
      end else if (busy_ff && do_mem) begin
         mem[addr[MemAw-1:2]] <= mw_new;
      end
   end

endmodule

>>> hw/rtl/mips_itype_execute_unit.sv
// ----------------------------------------------------------------------------
// mips_itype_execute_unit: MIPS I-type instruction executor
// Front classifier, two-entry queue and a two-phase execution back end.
// ----------------------------------------------------------------------------
// Each request beat carries one I-type instruction; each response beat carries
// the next PC and four status flags. The back end executes each instruction in
// two phases (operand and memory-word read, then write back) and takes no new
// instruction during the write-back phase. The front end classifies the opcode
// and buffers up to two instructions. A new instruction enters the back end
// only once the previous response beat has been taken, or is taken in that
// same cycle, so a stalled response channel holds execution while the front
// end keeps buffering. After reset the data memory is cleared by a sweep over
// every word, one word per cycle, during which no instruction is executed
// (requests still queue in the front end).
module mips_itype_execute_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  miex_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output miex_pkg::rsp_type rsp_data
);
   import miex_pkg::*;

   // Queue between the classifier and the execution engine.
   logic      q_valid;
   logic      q_ready;
   entry_type q_data;

   miex_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data)
   );

   miex_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
